### sv/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the RTL; clocked, with synchronous reset disable.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: whenever cond holds, expr must hold too.
`define ASSERT_IMPLY(label, clk, rst, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error("assertion failed: cond implies expr");

// Next-cycle implication: when cond holds, expr must hold in the next cycle.
`define ASSERT_NEXT(label, clk, rst, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error("assertion failed: cond implies expr on the next cycle");

`endif

### sv/psrt_pkg.sv
// ---------------------------------------------------------------------------
// psrt_pkg
// Types and constants for the relay session timer.
// ---------------------------------------------------------------------------
package psrt_pkg;

  localparam int S_TDATA_W = 72;   // 67 bits of fields, padded to bytes
  localparam int M_TDATA_W = 88;   // 83 bits of fields, padded to bytes
  localparam int PADDR_W   = 3;

  localparam int SEC_W = 22;       // width of a seconds result
  localparam int REM_W = 31;       // positive remaining milliseconds

  localparam logic [31:0] MS_PER_SEC = 32'd1000;
  localparam logic [31:0] ROUND_UP   = 32'd999;
  // Largest second count whose millisecond product still fits in 32 bits
  localparam logic [31:0] MAX_SEC    = 32'd4294967;
  // floor(x / 1000) == (x * RECIP_1000) >> RECIP_SHIFT for any 32-bit x
  localparam logic [28:0] RECIP_1000  = 29'h10624DD3;
  localparam int          RECIP_SHIFT = 38;

  localparam logic [31:0] CKPT_RESET = 32'd60000;

  typedef enum logic [2:0] {
    CMD_TICK  = 3'd0,
    CMD_START = 3'd1,
    CMD_ADD   = 3'd2,
    CMD_STOP  = 3'd3,
    CMD_BOOT  = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE     = 2'd0,
    ST_ACTIVE   = 2'd1,
    ST_RECOVERY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    SAVE_NONE  = 2'd0,
    SAVE_WRITE = 2'd1,
    SAVE_CLEAR = 2'd2
  } save_t;

  // Register index, taken from paddr[2]
  typedef enum logic {
    REG_POLARITY = 1'b0,
    REG_CKPT     = 1'b1
  } reg_t;

  // Result of the update stage, before the seconds conversion
  typedef struct packed {
    logic             relay_on;
    status_t          status;
    logic [REM_W-1:0] rem_ms;
    save_t            action;
    logic [31:0]      recovery;
    logic             finished;
  } upd_t;

endpackage

### sv/paid_session_relay_timer.sv
// ---------------------------------------------------------------------------
// paid_session_relay_timer
// Command-driven relay session timer with millisecond clock, deadline check,
// periodic checkpoint requests and boot-time recovery.
// ---------------------------------------------------------------------------
//
//  Channel   Direction  Carries
//  s_axis    in         command, duration_seconds, saved_seconds
//  m_axis    out        relay level/state, status, seconds, save request
//  apb       in/out     relay polarity (0x0), checkpoint_interval_ms (0x4)
//
//  Three register stages: input, state update, seconds conversion/output.
//  One item per cycle is sustained while m_tready holds; an item accepted
//  passes the input, update and output registers to m_axis. Session state
//  updates as an item leaves the input stage, so the next item always sees it.
//  The ceiling divide by 1000 is a reciprocal multiply in the last stage.
//  rst is synchronous: clears session state, valids and the config registers.
//  A stalled output backs up the stages; s_tready drops only when all are full.
//
`include "assert_macros.svh"

module paid_session_relay_timer (
  input  logic                            clk,
  input  logic                            rst,
  // slave stream
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // [2:0] command, [34:3] duration_seconds, [66:35] saved_seconds
  input  logic [psrt_pkg::S_TDATA_W-1:0]  s_tdata,
  // master stream
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // [0] relay_level, [1] relay_on, [3:2] session_status,
  // [25:4] remaining_seconds, [27:26] save_action, [49:28] save_value,
  // [81:50] recovery_seconds, [82] auto_finished
  output logic [psrt_pkg::M_TDATA_W-1:0]  m_tdata,
  // configuration
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [psrt_pkg::PADDR_W-1:0]    paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  import psrt_pkg::*;

  // ---- configuration registers ----
  logic        pol_high;
  logic [31:0] checkpoint_interval_ms;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      pol_high               <= 1'b1;
      checkpoint_interval_ms <= CKPT_RESET;
    end else if (cfg_wr) begin
      case (reg_t'(paddr[2]))
        REG_POLARITY: pol_high               <= pwdata[0];
        REG_CKPT:     checkpoint_interval_ms <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_t'(paddr[2]))
      REG_POLARITY: prdata = {31'd0, pol_high};
      REG_CKPT:     prdata = checkpoint_interval_ms;
      default:      prdata = 32'd0;
    endcase
  end

  // ---- stage enables: a stage advances when empty or when its successor moves ----
  logic v1, v2, v3;
  logic en1, en2, en3;

  assign en3      = !v3 || m_tready;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign s_tready = en1;

  // ---- stage 1: input register ----
  logic [2:0]  in_cmd;
  logic [31:0] in_dur;
  logic [31:0] in_saved;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && s_tvalid) begin
      in_cmd   <= s_tdata[2:0];
      in_dur   <= s_tdata[34:3];
      in_saved <= s_tdata[66:35];
    end
  end

  // ---- session state ----
  logic        [31:0] now_ms,  now_ms_next;
  logic        [31:0] deadline_ms, deadline_ms_next;
  logic               relay_flag, relay_flag_next;
  logic        [31:0] last_ckpt_ms, last_ckpt_ms_next;
  logic        [31:0] recovery_amount, recovery_amount_next;
  status_t            status_code, status_code_next;

  // ---- stage 2: state update ----
  logic [31:0] dur_ms;
  logic [31:0] tick_now;
  logic [31:0] tick_gap;
  logic [31:0] tick_since;
  logic [31:0] now_gap;
  logic [31:0] rem_diff;
  logic        rem_ok;
  logic        do_persist;
  save_t       action;
  logic        finished;
  upd_t        upd, upd_next;

  // Saturate the second-to-millisecond product at all ones
  assign dur_ms     = (in_dur > MAX_SEC) ? 32'hFFFF_FFFF : in_dur * MS_PER_SEC;
  assign tick_now   = now_ms + 32'd1;
  assign tick_gap   = tick_now - deadline_ms;
  assign tick_since = tick_now - last_ckpt_ms;
  assign now_gap    = now_ms - deadline_ms;

  always_comb begin
    now_ms_next          = now_ms;
    deadline_ms_next     = deadline_ms;
    relay_flag_next      = relay_flag;
    last_ckpt_ms_next    = last_ckpt_ms;
    recovery_amount_next = recovery_amount;
    status_code_next     = status_code;
    action               = SAVE_NONE;
    finished             = 1'b0;
    do_persist           = 1'b0;

    case (in_cmd)
      CMD_TICK: begin
        now_ms_next = tick_now;
        // Deadline first (wrap-safe sign test), then the checkpoint interval
        if (relay_flag && !tick_gap[31]) begin
          deadline_ms_next     = 32'd0;
          status_code_next     = ST_IDLE;
          recovery_amount_next = 32'd0;
          relay_flag_next      = 1'b0;
          action               = SAVE_CLEAR;
          finished             = 1'b1;
        end else if (relay_flag && (tick_since >= checkpoint_interval_ms)) begin
          do_persist = 1'b1;
        end
      end
      CMD_START, CMD_ADD: begin
        // Extend from the later of now and deadline; idle add acts as start
        if (in_cmd == CMD_ADD && relay_flag) begin
          deadline_ms_next = (now_gap[31] ? deadline_ms : now_ms) + dur_ms;
        end else begin
          deadline_ms_next = now_ms + dur_ms;
        end
        relay_flag_next      = 1'b1;
        status_code_next     = ST_ACTIVE;
        recovery_amount_next = 32'd0;
        do_persist           = 1'b1;
      end
      CMD_STOP: begin
        deadline_ms_next     = 32'd0;
        status_code_next     = ST_IDLE;
        recovery_amount_next = 32'd0;
        relay_flag_next      = 1'b0;
        action               = SAVE_CLEAR;
      end
      CMD_BOOT: begin
        relay_flag_next      = 1'b0;
        deadline_ms_next     = 32'd0;
        recovery_amount_next = in_saved;
        status_code_next     = (in_saved != 32'd0) ? ST_RECOVERY : ST_IDLE;
      end
      default: ;
    endcase

    // Remaining time on the updated state; zero or negative means none left
    rem_diff = deadline_ms_next - now_ms_next;
    rem_ok   = relay_flag_next && (rem_diff != 32'd0) && !rem_diff[31];

    if (do_persist) begin
      if (rem_ok) begin
        action            = SAVE_WRITE;
        last_ckpt_ms_next = now_ms_next;
      end else begin
        action = SAVE_CLEAR;
      end
    end

    upd_next.relay_on = relay_flag_next;
    upd_next.status   = status_code_next;
    upd_next.rem_ms   = rem_ok ? rem_diff[REM_W-1:0] : '0;
    upd_next.action   = action;
    upd_next.recovery = recovery_amount_next;
    upd_next.finished = finished;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      now_ms          <= 32'd0;
      deadline_ms     <= 32'd0;
      relay_flag      <= 1'b0;
      last_ckpt_ms    <= 32'd0;
      recovery_amount <= 32'd0;
      status_code     <= ST_IDLE;
      v2              <= 1'b0;
    end else if (en2) begin
      v2 <= v1;
      // Commit session state once per item, as it moves into stage 2
      if (v1) begin
        now_ms          <= now_ms_next;
        deadline_ms     <= deadline_ms_next;
        relay_flag      <= relay_flag_next;
        last_ckpt_ms    <= last_ckpt_ms_next;
        recovery_amount <= recovery_amount_next;
        status_code     <= status_code_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en2 && v1) begin
      upd <= upd_next;
    end
  end

  // ---- stage 3: ceiling seconds and output register ----
  logic [31:0]            rem_round;
  logic [31+RECIP_SHIFT-9:0] rem_prod;
  logic [SEC_W-1:0]       rem_sec;

  logic                   out_level;
  logic                   out_relay_on;
  status_t                out_status;
  logic [SEC_W-1:0]       out_remaining;
  save_t                  out_action;
  logic [SEC_W-1:0]       out_value;
  logic [31:0]            out_recovery;
  logic                   out_finished;

  // rem_ms < 2^31, so the rounded value fits in 32 bits
  assign rem_round = {1'b0, upd.rem_ms} + ROUND_UP;
  assign rem_prod  = rem_round * RECIP_1000;
  assign rem_sec   = rem_prod[RECIP_SHIFT +: SEC_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en3 && v2) begin
      out_level     <= pol_high ? upd.relay_on : !upd.relay_on;
      out_relay_on  <= upd.relay_on;
      out_status    <= upd.status;
      out_remaining <= rem_sec;
      out_action    <= upd.action;
      out_value     <= (upd.action == SAVE_WRITE) ? rem_sec : '0;
      out_recovery  <= upd.recovery;
      out_finished  <= upd.finished;
    end
  end

  assign m_tvalid = v3;
  assign m_tdata  = {5'd0, out_finished, out_recovery, out_value, out_action,
                     out_remaining, out_status, out_relay_on, out_level};

  // ---- assertions ----
  `ASSERT_IMPLY(a_value_only_on_write, clk, rst,
    v3 && (out_value != '0), out_action == SAVE_WRITE)
  `ASSERT_IMPLY(a_finish_clears, clk, rst,
    v3 && out_finished, !out_relay_on && (out_action == SAVE_CLEAR))
  `ASSERT_IMPLY(a_off_no_time, clk, rst,
    v3 && !out_relay_on, out_remaining == '0)
  `ASSERT_IMPLY(a_status_tracks_relay, clk, rst,
    1'b1, relay_flag == (status_code == ST_ACTIVE))
  `ASSERT_NEXT(a_state_held_without_item, clk, rst,
    !(en2 && v1), $stable(now_ms) && $stable(deadline_ms))

endmodule

### tb/paid_session_relay_timer_tb.sv
// ---------------------------------------------------------------------------
// paid_session_relay_timer_tb
// Self-checking bench for the relay session timer. A clocked driver feeds
// command items from a backlog queue, a behavioral session model predicts
// each result at acceptance, and a clocked monitor compares every field.
// Directed corner items run first, then session sequences and noise under
// several idling patterns and register settings, with one long output stall.
// ---------------------------------------------------------------------------
module paid_session_relay_timer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import psrt_pkg::*;

  // Largest second count whose millisecond product does not saturate
  localparam bit [31:0] MAX_EXACT_SEC  = 32'd4294967;
  // Adding this many seconds wraps the deadline back by 296 ms
  localparam bit [31:0] PULL_BACK_SEC  = 32'd4294967;
  localparam bit [31:0] MS_IN_SEC      = 32'd1000;
  localparam bit [2:0]  CMD_UNUSED_LO  = 3'd5;
  localparam bit [2:0]  CMD_UNUSED_HI  = 3'd7;
  localparam int        HOLD_CYCLES    = 300;
  localparam int        PRINT_CAP      = 30;
  localparam int        PHASE_ITEMS    = 170;
  localparam int        SETTLE_CYCLES  = 8;

  typedef struct {
    bit [2:0]  command;
    bit [31:0] duration;
    bit [31:0] saved;
  } relay_cmd_t;

  typedef struct {
    bit          level;
    bit          relay_on;
    status_t     status;
    bit [21:0]   remaining;
    save_t       action;
    bit [21:0]   value;
    bit [31:0]   recovery;
    bit          finished;
  } relay_report_t;

  logic                 clk;
  logic                 rst      = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata  = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic                 psel     = 1'b0;
  logic                 penable  = 1'b0;
  logic                 pwrite   = 1'b0;
  logic [PADDR_W-1:0]   paddr    = '0;
  logic [31:0]          pwdata   = '0;
  logic [31:0]          prdata;
  logic                 pready;

  paid_session_relay_timer i_dut (.*);

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // -------------------------------------------------------------------------
  // Session model: its own copy of the timer state and the two registers
  // -------------------------------------------------------------------------
  bit [31:0] now_ms_q        = '0;
  bit [31:0] deadline_q      = '0;
  bit [31:0] last_ckpt_q     = '0;
  bit [31:0] recovery_q      = '0;
  bit        relay_q         = 1'b0;
  status_t   status_q        = ST_IDLE;
  bit        polarity_q      = 1'b1;
  bit [31:0] ckpt_interval_q = CKPT_RESET;

  relay_cmd_t    cmd_backlog[$];
  relay_report_t reports_due[$];
  relay_cmd_t    on_offer;

  int  send_gap_pct   = 0;
  int  recv_stall_pct = 0;
  bit  pressure_go    = 1'b0;
  logic rx_hold       = 1'b0;

  int  mismatch_count  = 0;
  int  results_checked = 0;
  int  expiries_seen   = 0;
  int  ckpt_writes     = 0;
  int  cmd_count[8];

  // Saturate the product, the caller lets the sum wrap
  function automatic bit [31:0] secs_to_ms(bit [31:0] secs);
    return (secs > MAX_EXACT_SEC) ? 32'hFFFF_FFFF : secs * MS_IN_SEC;
  endfunction

  // Wrap-safe compare: reached when now - deadline is non-negative as signed
  function automatic bit deadline_passed();
    bit [31:0] gap;
    gap = now_ms_q - deadline_q;
    return ~gap[31];
  endfunction

  function automatic bit [21:0] seconds_left();
    bit [31:0] gap;
    gap = deadline_q - now_ms_q;
    if (!relay_q || gap == 0 || gap[31]) return '0;
    return 22'((gap + 32'd999) / MS_IN_SEC);
  endfunction

  // Request a write of the remaining seconds, or a clear when nothing is left
  function automatic void take_checkpoint(output save_t act, output bit [21:0] val);
    bit [21:0] secs;
    secs = seconds_left();
    if (!relay_q || secs == 0) begin
      act = SAVE_CLEAR;
      val = '0;
    end else begin
      act = SAVE_WRITE;
      val = secs;
      last_ckpt_q = now_ms_q;
    end
  endfunction

  function automatic void close_session();
    deadline_q = '0;
    status_q   = ST_IDLE;
    recovery_q = '0;
    relay_q    = 1'b0;
  endfunction

  function automatic void open_session(bit [31:0] secs, output save_t act,
                                       output bit [21:0] val);
    recovery_q = '0;
    deadline_q = now_ms_q + secs_to_ms(secs);
    status_q   = ST_ACTIVE;
    relay_q    = 1'b1;
    take_checkpoint(act, val);
  endfunction

  // Apply one command item to the model and build the result it must produce
  function automatic relay_report_t advance_session(relay_cmd_t c);
    relay_report_t rep;
    bit [31:0]     base;
    rep.action   = SAVE_NONE;
    rep.value    = '0;
    rep.finished = 1'b0;
    case (c.command)
      CMD_TICK: begin
        // advance the clock first, test the deadline before the checkpoint
        now_ms_q = now_ms_q + 1;
        if (relay_q && deadline_passed()) begin
          close_session();
          rep.action   = SAVE_CLEAR;
          rep.finished = 1'b1;
        end else if (relay_q && (now_ms_q - last_ckpt_q) >= ckpt_interval_q) begin
          take_checkpoint(rep.action, rep.value);
        end
      end
      CMD_START: open_session(c.duration, rep.action, rep.value);
      CMD_ADD: begin
        if (!relay_q) begin
          open_session(c.duration, rep.action, rep.value);
        end else begin
          // extend from now once the deadline has already gone by
          base       = deadline_passed() ? now_ms_q : deadline_q;
          deadline_q = base + secs_to_ms(c.duration);
          status_q   = ST_ACTIVE;
          recovery_q = '0;
          take_checkpoint(rep.action, rep.value);
        end
      end
      CMD_STOP: begin
        close_session();
        rep.action = SAVE_CLEAR;
      end
      CMD_BOOT: begin
        relay_q    = 1'b0;
        deadline_q = '0;
        recovery_q = c.saved;
        status_q   = (c.saved != 0) ? ST_RECOVERY : ST_IDLE;
      end
      default: ;
    endcase
    rep.relay_on  = relay_q;
    rep.level     = polarity_q ? relay_q : ~relay_q;
    rep.status    = status_q;
    rep.remaining = seconds_left();
    rep.recovery  = recovery_q;
    return rep;
  endfunction

  task automatic flag_mismatch(string what, longint unsigned got, longint unsigned want);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP)
      $display("[%0t] MISMATCH %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
  endtask

  // -------------------------------------------------------------------------
  // Driver: hold an offered item until taken, predict on acceptance
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        reports_due.push_back(advance_session(on_offer));
        cmd_count[on_offer.command]++;
      end
      if (!s_tvalid || s_tready) begin
        if (cmd_backlog.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          on_offer = cmd_backlog.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= {5'b0, on_offer.saved, on_offer.duration, on_offer.command};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // -------------------------------------------------------------------------
  // Monitor: compare each taken result with the oldest expectation
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    relay_report_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (reports_due.size() == 0) begin
          flag_mismatch("result with nothing expected", m_tdata[63:0], 0);
        end else begin
          want = reports_due.pop_front();
          results_checked++;
          if (want.finished) expiries_seen++;
          if (want.action == SAVE_WRITE) ckpt_writes++;
          if (m_tdata[0] !== want.level)
            flag_mismatch("relay_level", m_tdata[0], want.level);
          if (m_tdata[1] !== want.relay_on)
            flag_mismatch("relay_on", m_tdata[1], want.relay_on);
          if (m_tdata[3:2] !== want.status)
            flag_mismatch("session_status", m_tdata[3:2], want.status);
          if (m_tdata[25:4] !== want.remaining)
            flag_mismatch("remaining_seconds", m_tdata[25:4], want.remaining);
          if (m_tdata[27:26] !== want.action)
            flag_mismatch("save_action", m_tdata[27:26], want.action);
          if (m_tdata[49:28] !== want.value)
            flag_mismatch("save_value", m_tdata[49:28], want.value);
          if (m_tdata[81:50] !== want.recovery)
            flag_mismatch("recovery_seconds", m_tdata[81:50], want.recovery);
          if (m_tdata[82] !== want.finished)
            flag_mismatch("auto_finished", m_tdata[82], want.finished);
        end
      end
      m_tready <= !rx_hold && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Long output stall: the sender keeps offering, so the pipeline backs up
  initial begin
    wait (pressure_go);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  // -------------------------------------------------------------------------
  // Stimulus helpers
  // -------------------------------------------------------------------------
  task automatic push_cmd(bit [2:0] command, bit [31:0] duration, bit [31:0] saved);
    relay_cmd_t c;
    c.command  = command;
    c.duration = duration;
    c.saved    = saved;
    cmd_backlog.push_back(c);
  endtask

  function automatic bit [31:0] pick_duration();
    case ($urandom_range(9))
      0, 1, 2, 3: return $urandom_range(10);
      4, 5:       return $urandom_range(32'd4294975, 32'd4294960);
      6:          return $urandom_range(32'd2147490, 32'd2147478);
      default:    return $urandom;
    endcase
  endfunction

  function automatic bit [31:0] pick_saved();
    case ($urandom_range(3))
      0:       return '0;
      1:       return $urandom_range(100);
      default: return $urandom;
    endcase
  endfunction

  task automatic push_noise();
    push_cmd(3'($urandom_range(CMD_UNUSED_HI)), pick_duration(), pick_saved());
  endtask

  // Start a session, pull its deadline back close to now with wrapping adds,
  // then tick past the expiry; now and then break in with another command
  task automatic push_session();
    int secs, pulls, trims, rem, ticks, cut_at, i;
    secs  = $urandom_range(9);
    pulls = (secs * 1000) / 296;
    if (pulls > 0 && $urandom_range(3) == 0) pulls -= $urandom_range(1);
    trims = $urandom_range(3);
    if ($urandom_range(1)) begin
      push_cmd(CMD_START, secs, $urandom);
    end else begin
      push_cmd(CMD_STOP, $urandom, $urandom);
      push_cmd(CMD_ADD, secs, $urandom);
    end
    rem = secs * 1000;
    for (i = 0; i < pulls; i++) begin
      push_cmd(CMD_ADD, PULL_BACK_SEC, $urandom);
      rem = (rem <= 0) ? -296 : rem - 296;
    end
    // saturated products move the deadline back by a single millisecond
    for (i = 0; i < trims; i++) begin
      push_cmd(CMD_ADD, $urandom_range(32'hFFFF_FFFF, MAX_EXACT_SEC + 1), $urandom);
      rem = (rem <= 0) ? -1 : rem - 1;
    end
    ticks = ((rem > 0) ? rem : 0) + $urandom_range(3, 1);
    if (ticks > 250) ticks = 250;
    cut_at = ($urandom_range(4) == 0) ? $urandom_range(ticks - 1) : -1;
    for (i = 0; i < ticks; i++) begin
      if (i == cut_at)
        push_cmd(3'($urandom_range(CMD_UNUSED_HI, CMD_STOP)), pick_duration(), pick_saved());
      push_cmd(CMD_TICK, $urandom, $urandom);
    end
  endtask

  task automatic push_random(int target);
    int i, burst;
    while (cmd_backlog.size() < target) begin
      if ($urandom_range(3) != 0) begin
        push_session();
      end else begin
        burst = $urandom_range(6, 1);
        for (i = 0; i < burst; i++) push_noise();
      end
    end
  endtask

  // Corner items: idle commands, unused codes, product and sum wrap cases
  task automatic push_directed();
    push_cmd(CMD_TICK, '0, '0);
    push_cmd(CMD_STOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);      // stop with nothing running
    push_cmd(CMD_BOOT, '0, '0);                            // nothing saved
    push_cmd(CMD_BOOT, '0, 32'hFFFF_FFFF);                 // recovery pending
    push_cmd(CMD_UNUSED_HI, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_cmd(CMD_UNUSED_LO, '0, '0);
    push_cmd(CMD_ADD, '0, '0);                             // add while idle acts as start
    push_cmd(CMD_TICK, '0, '0);                            // expires at once
    push_cmd(CMD_START, 32'd2147483, '0);                  // longest positive remainder
    push_cmd(CMD_ADD, 32'd1, '0);
    push_cmd(CMD_BOOT, '0, 32'd5);                         // boot in mid-session
    push_cmd(CMD_START, 32'd2147484, '0);                  // remainder looks negative
    push_cmd(CMD_TICK, '0, '0);
    push_cmd(CMD_START, MAX_EXACT_SEC, '0);                // sum wraps behind now
    push_cmd(CMD_ADD, 32'hFFFF_FFFF, '0);                  // add after the deadline
    push_cmd(CMD_TICK, '0, '0);
    push_cmd(CMD_START, MAX_EXACT_SEC + 1, '0);            // saturated product
    push_cmd(CMD_STOP, '0, '0);
    push_cmd(CMD_START, 32'd1, '0);
    repeat (3) push_cmd(CMD_ADD, PULL_BACK_SEC, '0);       // 112 ms left
    push_cmd(CMD_TICK, 32'hFFFF_FFFF, 32'hFFFF_FFFF);      // tick ignores its fields
    push_cmd(CMD_STOP, '0, '0);
  endtask

  // Wait for the backlog and the expectations to empty, then let the
  // pipeline settle so a register write never overlaps an item
  task automatic drain();
    while (cmd_backlog.size() != 0 || s_tvalid || reports_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(reg_t idx, bit [31:0] val);
    bit [31:0] expect_rd;
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == REG_POLARITY) polarity_q = val[0];
    else ckpt_interval_q = val;
    expect_rd = (idx == REG_POLARITY) ? {31'b0, val[0]} : val;
    // read back through a second transfer
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== expect_rd) flag_mismatch("register read", prdata, expect_rd);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // -------------------------------------------------------------------------
  // Test sequence
  // -------------------------------------------------------------------------
  int        gap_set[6]   = '{0, 54, 0, 17, 0, 17};
  int        stall_set[6] = '{0, 0, 54, 17, 0, 17};
  bit        pol_set[6]   = '{1, 0, 1, 0, 1, 0};
  bit [31:0] ivl_set[6]   = '{CKPT_RESET, 32'd0, 32'd5, 32'hFFFF_FFFF, 32'd1, 32'd0};

  initial begin
    int p;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // reset register values first
    push_directed();
    drain();

    // fill the pipeline against a stalled output
    push_cmd(CMD_START, 32'd3, '0);
    repeat (60) push_cmd(CMD_TICK, $urandom, $urandom);
    pressure_go = 1'b1;
    drain();

    ivl_set[5] = $urandom_range(40, 2);
    for (p = 1; p < 6; p++) begin
      send_gap_pct   = gap_set[p];
      recv_stall_pct = stall_set[p];
      write_reg(REG_POLARITY, pol_set[p]);
      write_reg(REG_CKPT, ivl_set[p]);
      push_random(PHASE_ITEMS);
      drain();
    end

    $display("Covered %0d ticks, %0d starts, %0d adds, %0d stops, %0d boots, %0d unused codes",
             cmd_count[CMD_TICK], cmd_count[CMD_START], cmd_count[CMD_ADD],
             cmd_count[CMD_STOP], cmd_count[CMD_BOOT],
             cmd_count[5] + cmd_count[6] + cmd_count[7]);
    $display("over six register settings; %0d results checked, %0d expiries, %0d saves",
             results_checked, expiries_seen, ckpt_writes);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run
  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
